### design/clr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clr_pkg: shared types and constants of the carrier recovery loop
// Holds the register map, the controller states and commands, and the
// elaboration-time function that builds the sine/cosine octant table.
// ----------------------------------------------------------------------------
package clr_pkg;

    localparam int SAMPLE_WIDTH_DEF      = 16;
    localparam int PHASE_WIDTH_DEF       = 32;
    localparam int SINCOS_TABLE_BITS_DEF = 10;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int GAIN_W     = 24;

    localparam logic [1:0] REG_PSK_ORDER = 2'd0;
    localparam logic [1:0] REG_ALPHA     = 2'd1;
    localparam logic [1:0] REG_BETA      = 2'd2;

    localparam logic [1:0] PSK_BPSK = 2'd0;
    localparam logic [1:0] PSK_QPSK = 2'd1;
    localparam logic [1:0] PSK_8PSK = 2'd2;

    localparam logic [1:0]        PSK_ORDER_RST = 2'd1;
    localparam logic [GAIN_W-1:0] ALPHA_RST     = 24'd37497;
    localparam logic [GAIN_W-1:0] BETA_RST      = 24'd265;

    localparam int          COEF_FRAC   = 30;
    localparam logic [63:0] COEF_ONE    = 64'd1 << COEF_FRAC;
    localparam logic [31:0] PI_HALF_Q30 = 32'd1686629713;
    localparam logic [31:0] K8_Q16      = 32'd27146;
    localparam logic [31:0] INV_2PI_Q32 = 32'd683565276;
    localparam int          GAIN_FRAC   = 24;

    typedef struct packed {
        logic [1:0]        psk_order;
        logic [GAIN_W-1:0] alpha_gain;
        logic [GAIN_W-1:0] beta_gain;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROTA,
        S_ROTB,
        S_SUM,
        S_ERRM,
        S_ERRF,
        S_GAIN,
        S_UPD,
        S_HOLD
    } state_t;

    typedef struct packed {
        logic load;
        logic rot_a;
        logic rot_b;
        logic sum;
        logic err_mul;
        logic err_fin;
        logic gain;
        logic upd;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

    // Sine and cosine of the octant offset r, both unsigned Q30, packed as
    // {sin, cos}. Evaluated only at elaboration to fill a constant table.
    function automatic logic [61:0] octant_entry(input int unsigned r, input int unsigned tb);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] us;
        x  = (64'(r) * 64'(PI_HALF_Q30) + (64'd1 << (tb - 3))) >> (tb - 2);
        x2 = (x * x + (64'd1 << (COEF_FRAC - 1))) >> COEF_FRAC;
        t  = COEF_ONE;
        t  = COEF_ONE - ((x2 * t) >> COEF_FRAC) / 64'd110;
        t  = COEF_ONE - ((x2 * t) >> COEF_FRAC) / 64'd72;
        t  = COEF_ONE - ((x2 * t) >> COEF_FRAC) / 64'd42;
        t  = COEF_ONE - ((x2 * t) >> COEF_FRAC) / 64'd20;
        t  = COEF_ONE - ((x2 * t) >> COEF_FRAC) / 64'd6;
        us = (x * t) >> COEF_FRAC;
        t  = COEF_ONE;
        t  = COEF_ONE - ((x2 * t) >> COEF_FRAC) / 64'd132;
        t  = COEF_ONE - ((x2 * t) >> COEF_FRAC) / 64'd90;
        t  = COEF_ONE - ((x2 * t) >> COEF_FRAC) / 64'd56;
        t  = COEF_ONE - ((x2 * t) >> COEF_FRAC) / 64'd30;
        t  = COEF_ONE - ((x2 * t) >> COEF_FRAC) / 64'd12;
        t  = COEF_ONE - ((x2 * t) >> COEF_FRAC) / 64'd2;
        return {us[30:0], t[30:0]};
    endfunction

endpackage
`default_nettype wire

### design/clr_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clr_regs: configuration register file
// APB-style write and read access to the order, proportional and integral
// gain registers.
// ----------------------------------------------------------------------------
module clr_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [clr_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [clr_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [clr_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output clr_pkg::cfg_t                       cfg
);
    import clr_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_PSK_ORDER: cfg_next.psk_order  = pwdata[1:0];
                REG_ALPHA:     cfg_next.alpha_gain = pwdata[GAIN_W-1:0];
                REG_BETA:      cfg_next.beta_gain  = pwdata[GAIN_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PSK_ORDER: prdata = {{(APB_DATA_W-2){1'b0}}, cfg_reg.psk_order};
            REG_ALPHA:     prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, cfg_reg.alpha_gain};
            REG_BETA:      prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, cfg_reg.beta_gain};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.psk_order  <= PSK_ORDER_RST;
            cfg_reg.alpha_gain <= ALPHA_RST;
            cfg_reg.beta_gain  <= BETA_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

### design/clr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clr_ctrl: sequencing controller
// Steps one sample through rotation, error detection and loop update.
// ----------------------------------------------------------------------------
module clr_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire clr_pkg::stat_t stat,
    output clr_pkg::cmd_t       cmd
);
    import clr_pkg::*;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid) state_next = S_ROTA;
            S_ROTA: state_next = S_ROTB;
            S_ROTB: state_next = S_SUM;
            S_SUM:  state_next = S_ERRM;
            S_ERRM: state_next = S_ERRF;
            S_ERRF: state_next = S_GAIN;
            S_GAIN: state_next = S_UPD;
            S_UPD:  state_next = stat.out_free ? S_IDLE : S_HOLD;
            S_HOLD: if (stat.out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE: cmd.load    = in_valid;
            S_ROTA: cmd.rot_a   = 1'b1;
            S_ROTB: cmd.rot_b   = 1'b1;
            S_SUM:  cmd.sum     = 1'b1;
            S_ERRM: cmd.err_mul = 1'b1;
            S_ERRF: cmd.err_fin = 1'b1;
            S_GAIN: cmd.gain    = 1'b1;
            S_UPD:
            begin
                cmd.upd  = 1'b1;
                cmd.push = stat.out_free;
            end
            S_HOLD: cmd.push = stat.out_free;
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

### design/clr_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clr_dp: loop datapath
// Sine/cosine table, two shared multipliers, rotation, phase error detector,
// loop filter with phase and frequency state, and the output register.
// ----------------------------------------------------------------------------
module clr_dp #(
    parameter int SAMPLE_WIDTH      = clr_pkg::SAMPLE_WIDTH_DEF,
    parameter int PHASE_WIDTH       = clr_pkg::PHASE_WIDTH_DEF,
    parameter int SINCOS_TABLE_BITS = clr_pkg::SINCOS_TABLE_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire clr_pkg::cmd_t                  cmd,
    output clr_pkg::stat_t                      stat,
    input  wire clr_pkg::cfg_t                  cfg,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample_i,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample_q,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic signed      [SAMPLE_WIDTH-1:0] out_i,
    output logic signed      [SAMPLE_WIDTH-1:0] out_q
);
    import clr_pkg::*;

    localparam int W    = SAMPLE_WIDTH;
    localparam int P    = PHASE_WIDTH;
    localparam int TB   = SINCOS_TABLE_BITS;
    localparam int F    = W - 2;
    localparam int PW   = W + 33;
    localparam int EW   = PW + 1;
    localparam int GW   = PW + 4;
    localparam int OW   = TB - 2;
    localparam int QTR  = 2 ** OW;
    localparam int HALF = 2 ** (OW - 1);
    localparam int GSH  = GAIN_FRAC + F - P;

    localparam logic signed [EW-1:0] RND30  = EW'(2 ** (COEF_FRAC - 1));
    localparam logic signed [EW-1:0] RNDF   = EW'(2 ** (F - 1));
    localparam logic signed [EW-1:0] RND16  = EW'(2 ** 15);
    localparam logic signed [EW-1:0] SMAX   = EW'(2 ** (W - 1) - 1);
    localparam logic signed [EW-1:0] SMIN   = EW'(-(2 ** (W - 1)));
    localparam logic signed [EW-1:0] E_ONE  = EW'(2 ** F);
    localparam logic signed [W-1:0]  ERR_ONE = W'(2 ** F);
    localparam logic signed [P-1:0]  FLIM   = P'(INV_2PI_Q32 >> (32 - P));
    localparam logic signed [GW-1:0] FLIM_W = GW'(FLIM);
    localparam logic        [OW:0]   QTR_V  = (OW + 1)'(QTR);

    // Octant table: {sin, cos} in Q30 for offsets up to one eighth turn.
    logic [61:0] sc_tab [QTR];
    for (genvar g = 0; g < QTR; g++)
    begin : g_tab
        localparam logic [61:0] ENTRY = (g <= HALF) ? octant_entry(g, TB) : 62'd0;
        assign sc_tab[g] = ENTRY;
    end

    logic signed [W-1:0]  si_reg, sq_reg;
    logic signed [31:0]   sn_reg, cs_reg, sn_next, cs_next;
    logic signed [PW-1:0] pa_reg, pb_reg, prod_a, prod_b;
    logic signed [PW-1:0] acc_i_reg, acc_q_reg;
    logic signed [W-1:0]  oi_reg, oq_reg, oi_next, oq_next;
    logic signed [W-1:0]  err_reg, err_next;
    logic        [P-1:0]  phase_reg, phase_next;
    logic signed [P-1:0]  freq_reg, freq_next;
    logic signed [W-1:0]  out_i_reg, out_q_reg;
    logic                 out_valid_reg, out_valid_next;

    // Table lookup from the top bits of the phase.
    logic [TB-1:0] idx;
    logic [1:0]    quad;
    logic [OW-1:0] roff, oidx;
    logic          swap;
    logic [61:0]   entry;
    logic signed [31:0] s_val, c_val;

    assign idx   = phase_reg[P-1 -: TB];
    assign quad  = idx[TB-1 -: 2];
    assign roff  = idx[OW-1:0];
    assign swap  = roff > OW'(HALF);
    assign oidx  = swap ? OW'(QTR_V - {1'b0, roff}) : roff;
    assign entry = sc_tab[oidx];
    assign s_val = swap ? {1'b0, entry[30:0]} : {1'b0, entry[61:31]};
    assign c_val = swap ? {1'b0, entry[61:31]} : {1'b0, entry[30:0]};

    always_comb
    begin
        case (quad)
            2'd0:    begin sn_next = s_val;  cs_next = c_val;  end
            2'd1:    begin sn_next = c_val;  cs_next = -s_val; end
            2'd2:    begin sn_next = -s_val; cs_next = -c_val; end
            default: begin sn_next = -c_val; cs_next = s_val;  end
        endcase
    end

    // Error detector terms from the saturated rotated sample.
    logic signed [W:0] ta, tb_t, ai, aq, minor;
    logic              major_i;

    assign ta      = (oi_reg > 0) ? (W+1)'(oq_reg) : -(W+1)'(oq_reg);
    assign tb_t    = (oq_reg > 0) ? (W+1)'(oi_reg) : -(W+1)'(oi_reg);
    assign ai      = (oi_reg < 0) ? -(W+1)'(oi_reg) : (W+1)'(oi_reg);
    assign aq      = (oq_reg < 0) ? -(W+1)'(oq_reg) : (W+1)'(oq_reg);
    assign major_i = ai >= aq;
    assign minor   = major_i ? tb_t : ta;

    // Two shared multipliers; operands chosen by the current step.
    logic signed [W:0]  mxa, mxb;
    logic signed [31:0] mya, myb;

    always_comb
    begin
        mxa = '0;
        mya = '0;
        mxb = '0;
        myb = '0;
        if (cmd.rot_a)
        begin
            mxa = (W+1)'(si_reg);
            mya = cs_reg;
            mxb = (W+1)'(sq_reg);
            myb = cs_reg;
        end
        else if (cmd.rot_b)
        begin
            mxa = (W+1)'(sq_reg);
            mya = sn_reg;
            mxb = (W+1)'(si_reg);
            myb = sn_reg;
        end
        else if (cmd.err_mul)
        begin
            if (cfg.psk_order == PSK_BPSK)
            begin
                mxa = (W+1)'(oi_reg);
                mya = 32'(oq_reg);
            end
            else
            begin
                mxa = minor;
                mya = K8_Q16;
            end
        end
        else if (cmd.gain)
        begin
            mxa = (W+1)'(err_reg);
            mya = {8'd0, cfg.beta_gain};
            mxb = (W+1)'(err_reg);
            myb = {8'd0, cfg.alpha_gain};
        end
    end

    assign prod_a = mxa * mya;
    assign prod_b = mxb * myb;

    // Rotation sums, rounding and saturation.
    logic signed [EW-1:0] sum_i, sum_q, shr_i, shr_q;

    assign sum_i = EW'(acc_i_reg) + EW'(pa_reg) + RND30;
    assign sum_q = EW'(acc_q_reg) - EW'(pb_reg) + RND30;
    assign shr_i = sum_i >>> COEF_FRAC;
    assign shr_q = sum_q >>> COEF_FRAC;

    always_comb
    begin
        if (shr_i > SMAX)      oi_next = W'(SMAX);
        else if (shr_i < SMIN) oi_next = W'(SMIN);
        else                   oi_next = W'(shr_i);
        if (shr_q > SMAX)      oq_next = W'(SMAX);
        else if (shr_q < SMIN) oq_next = W'(SMIN);
        else                   oq_next = W'(shr_q);
    end

    // Phase error, clipped to plus or minus one.
    logic signed [EW-1:0] e_raw, e_k;

    assign e_k = (EW'(pa_reg) + RND16) >>> 16;

    always_comb
    begin
        case (cfg.psk_order)
            PSK_BPSK: e_raw = (EW'(pa_reg) + RNDF) >>> F;
            PSK_QPSK: e_raw = EW'(ta) - EW'(tb_t);
            PSK_8PSK: e_raw = major_i ? (EW'(ta) - e_k) : (e_k - EW'(tb_t));
            default:  e_raw = '0;
        endcase
        if (e_raw > E_ONE)       err_next = ERR_ONE;
        else if (e_raw < -E_ONE) err_next = -ERR_ONE;
        else                     err_next = W'(e_raw);
    end

    // Gain products scaled to phase units.
    logic signed [GW-1:0] gb, ga, fnew, psum;

    if (GSH > 0)
    begin : g_rshift
        localparam logic signed [GW-1:0] GRND = GW'(2 ** (GSH - 1));
        assign gb = (GW'(pa_reg) + GRND) >>> GSH;
        assign ga = (GW'(pb_reg) + GRND) >>> GSH;
    end
    else
    begin : g_lshift
        assign gb = GW'(pa_reg) <<< (-GSH);
        assign ga = GW'(pb_reg) <<< (-GSH);
    end

    assign fnew       = GW'(freq_reg) + gb;
    assign psum       = fnew + ga;
    assign phase_next = cmd.upd ? (phase_reg + psum[P-1:0]) : phase_reg;

    always_comb
    begin
        freq_next = freq_reg;
        if (cmd.upd)
        begin
            if (fnew > FLIM_W)       freq_next = FLIM;
            else if (fnew < -FLIM_W) freq_next = -FLIM;
            else                     freq_next = P'(fnew);
        end
    end

    // Output register.
    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid_next = cmd.push ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    assign out_valid      = out_valid_reg;
    assign out_i          = out_i_reg;
    assign out_q          = out_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            freq_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            freq_reg      <= freq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pa_reg <= prod_a;
        pb_reg <= prod_b;
        if (cmd.load)
        begin
            si_reg <= sample_i;
            sq_reg <= sample_q;
            sn_reg <= sn_next;
            cs_reg <= cs_next;
        end
        if (cmd.rot_b)
        begin
            acc_i_reg <= pa_reg;
            acc_q_reg <= pb_reg;
        end
        if (cmd.sum)
        begin
            oi_reg <= oi_next;
            oq_reg <= oq_next;
        end
        if (cmd.err_fin)
        begin
            err_reg <= err_next;
        end
        if (cmd.push)
        begin
            out_i_reg <= oi_reg;
            out_q_reg <= oq_reg;
        end
    end

    a_freq_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (freq_reg <= FLIM) && (freq_reg >= -FLIM))
        else $error("carrier frequency outside its limit");

    a_err_clip: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.gain |-> ((err_reg <= ERR_ONE) && (err_reg >= -ERR_ONE)))
        else $error("phase error outside plus or minus one");

    a_push_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> out_valid_reg)
        else $error("pushed result not presented");

endmodule
`default_nettype wire

### design/costas_loop_carrier_recovery_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// costas_loop_carrier_recovery_top: BPSK/QPSK/8-PSK carrier recovery loop
// Derotates each complex sample by the tracked carrier phase and updates
// a second-order phase/frequency loop from the detected phase error.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Contents
//  input     in         in_valid / in_ready    sample_i, sample_q
//  output    out        out_valid / out_ready  out_i, out_q
//  config    in/out     psel, penable, pready  psk_order, alpha_gain, beta_gain
//
// Each sample runs from the transfer that accepts it to the edge that loads
// its result into the output register through a serial chain: the two shared
// multipliers (rotation in two steps, error product, gain products) and the
// loop update. The sequencer then returns to idle before it can take the
// next sample, so a new sample is not accepted while one is in progress.
// A result that is not taken holds the sequencer until the output register
// frees up; one finished result can wait there while the next sample runs.
// Reset clears the phase, the frequency, the output valid flag and loads the
// register defaults (QPSK, alpha 37497, beta 265).
//
module costas_loop_carrier_recovery_top #(
    parameter int SAMPLE_WIDTH      = clr_pkg::SAMPLE_WIDTH_DEF,
    parameter int PHASE_WIDTH       = clr_pkg::PHASE_WIDTH_DEF,
    parameter int SINCOS_TABLE_BITS = clr_pkg::SINCOS_TABLE_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]      sample_i,
    input  wire logic signed [SAMPLE_WIDTH-1:0]      sample_q,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed      [SAMPLE_WIDTH-1:0]      out_i,
    output logic signed      [SAMPLE_WIDTH-1:0]      out_q,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic        [clr_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic        [clr_pkg::APB_DATA_W-1:0] pwdata,
    output logic             [clr_pkg::APB_DATA_W-1:0] prdata,
    output logic                                     pready
);
    import clr_pkg::*;

    // Configuration as seen by the datapath.
    cfg_t  cfg;
    // Step commands from the sequencer and the output-side status back.
    cmd_t  cmd;
    stat_t stat;

    clr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The controller accepts a sample only when the sequence is idle, then
    // walks the datapath through its steps.
    clr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath owns the carrier phase and frequency and the output
    // register that separates the loop from the downstream side.
    clr_dp #(
        .SAMPLE_WIDTH      (SAMPLE_WIDTH),
        .PHASE_WIDTH       (PHASE_WIDTH),
        .SINCOS_TABLE_BITS (SINCOS_TABLE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg       (cfg),
        .sample_i  (sample_i),
        .sample_q  (sample_q),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_i     (out_i),
        .out_q     (out_q)
    );

endmodule
`default_nettype wire
